@@ rtl/sdf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the smooth damp follower
// Fixed-point constants, shared-unit request/response types, sequencer
// states and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  // shared unit step counts
  localparam int MUL_CHUNK  = 16;
  localparam int MUL_STEPS  = 64 / MUL_CHUNK;
  localparam int DIV_STEPS  = 128;
  localparam int SQRT_STEPS = 35;
  localparam int CNT_W      = 8;

  localparam longint ONE_L   = longint'(1) << FRAC_BITS;
  localparam longint STMIN_Q = (ONE_L + 5000) / 10000;
  localparam logic [CFG_DATA_W-1:0] ST_MIN =
      CFG_DATA_W'((STMIN_Q == 0) ? 1 : STMIN_Q);
  localparam logic [63:0] ONE_RAW  = 64'(ONE_L);
  localparam logic [63:0] C48_RAW  = 64'((48 * ONE_L + 50) / 100);
  localparam logic [63:0] C235_RAW = 64'((235 * ONE_L + 500) / 1000);
  localparam logic [60:0] UCAP     = 61'd1 << 60;
  localparam logic [30:0] OMEGA_MAX = 31'h7FFF_FFFF;
  localparam logic [127:0] OMEGA_NUM = 128'd1 << (2 * FRAC_BITS + 1);
  localparam logic [127:0] DEC_NUM   = 128'd1 << (2 * FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH_TIME = 2'd0,
    REG_MAX_SPEED   = 2'd1,
    REG_DELTA_TIME  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] smooth_time;
    logic [CFG_DATA_W-1:0] max_speed;
    logic [CFG_DATA_W-1:0] delta_time;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic          start;
    alu_op_t       op;
    logic [127:0]  a;
    logic [63:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [127:0]  res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_OMEGA, S_X, S_X2, S_X3, S_T48, S_T235, S_DEC, S_MC, S_MCSQ,
    S_SQ, S_CMP, S_MAG, S_LIM_M, S_LIM_D, S_TM1, S_TM2, S_NV1, S_NV2,
    S_OX, S_DOT, S_FIN
  } seq_state_t;

  // product scaled back by FRAC_BITS, capped at the unsigned ceiling
  function automatic logic [60:0] umulq_cap(input logic [127:0] p);
    logic [127:0] q;
    q = p >> FRAC_BITS;
    if (q > {67'd0, UCAP}) return UCAP;
    return q[60:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

`default_nettype wire

@@ rtl/sdf_if.sv @@
// ----------------------------------------------------------------------------
// sdf_if: valid/ready channels of the smooth damp follower
// Input channel carries current and goal positions, output channel the
// new position and the snap flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [sdf_pkg::POS_W-1:0] cur_x;
  logic signed [sdf_pkg::POS_W-1:0] cur_y;
  logic signed [sdf_pkg::POS_W-1:0] goal_x;
  logic signed [sdf_pkg::POS_W-1:0] goal_y;

  modport source(output valid, cur_x, cur_y, goal_x, goal_y, input ready);
  modport sink(input valid, cur_x, cur_y, goal_x, goal_y, output ready);
endinterface

interface sdf_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [sdf_pkg::POS_W-1:0] out_x;
  logic signed [sdf_pkg::POS_W-1:0] out_y;
  logic                           snapped;

  modport source(output valid, out_x, out_y, snapped, input ready);
  modport sink(input valid, out_x, out_y, snapped, output ready);
endinterface

`default_nettype wire

@@ rtl/sdf_alu.sv @@
// ----------------------------------------------------------------------------
// sdf_alu: shared iterative arithmetic unit
// Multiply 64x64 in 16-bit chunks, restoring divide 128/64 one bit a cycle,
// and integer square root two radicand bits a cycle on one subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  sdf_pkg::alu_req_t req,
  output sdf_pkg::alu_rsp_t rsp
);
  import sdf_pkg::*;

  logic             busy_r;
  logic             done_r;
  alu_op_t          op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [127:0]     acc_r;
  logic [127:0]     num_r;
  logic [63:0]      d_r;
  logic [63:0]      rem_r;
  logic [34:0]      root_r;

  logic [79:0]      prod_c;
  logic [65:0]      lhs_c;
  logic [65:0]      rhs_c;
  logic [66:0]      diff_c;
  logic             ge_c;

  // multiplier chunk product
  assign prod_c = 80'(d_r) * 80'(num_r[127 -: MUL_CHUNK]);

  // shared trial subtract for divide and square root
  always_comb begin
    if (op_r == OP_SQRT) begin
      lhs_c = {28'd0, rem_r[35:0], num_r[127:126]};
      rhs_c = {29'd0, root_r, 2'b01};
    end else begin
      lhs_c = {1'b0, rem_r, num_r[127]};
      rhs_c = {2'd0, d_r};
    end
    diff_c = {1'b0, lhs_c} - {1'b0, rhs_c};
    ge_c   = !diff_c[66];
  end

  // load and step the unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        rem_r  <= '0;
        root_r <= '0;
        acc_r  <= '0;
        case (req.op)
          OP_DIV: begin
            num_r <= req.a;
            d_r   <= req.b;
            cnt_r <= CNT_W'(DIV_STEPS);
          end
          OP_SQRT: begin
            num_r <= {req.a[69:0], 58'd0};
            d_r   <= req.b;
            cnt_r <= CNT_W'(SQRT_STEPS);
          end
          default: begin
            num_r <= {req.b, 64'd0};
            d_r   <= req.a[63:0];
            cnt_r <= CNT_W'(MUL_STEPS);
          end
        endcase
      end else if (busy_r) begin
        case (op_r)
          OP_DIV: begin
            rem_r <= ge_c ? diff_c[63:0] : lhs_c[63:0];
            num_r <= {num_r[126:0], ge_c};
          end
          OP_SQRT: begin
            rem_r  <= ge_c ? diff_c[63:0] : lhs_c[63:0];
            root_r <= {root_r[33:0], ge_c};
            num_r  <= num_r << 2;
          end
          default: begin
            acc_r <= (acc_r << MUL_CHUNK) + 128'(prod_c);
            num_r <= num_r << MUL_CHUNK;
          end
        endcase
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // result select
  always_comb begin
    rsp.done = done_r;
    case (op_r)
      OP_DIV:  rsp.res = num_r;
      OP_SQRT: rsp.res = {93'd0, root_r};
      default: rsp.res = acc_r;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sdf_seq.sv @@
// ----------------------------------------------------------------------------
// sdf_seq: step sequencer of the smooth damp follower
// Walks one transaction through the spring step, feeding the shared unit,
// holding intermediates, the velocity state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  sdf_pkg::cfg_t     cfg,
  output sdf_pkg::alu_req_t alu_req,
  input  sdf_pkg::alu_rsp_t alu_rsp,
  sdf_in_if.sink            in_ch,
  sdf_out_if.source         out_ch
);
  import sdf_pkg::*;

  seq_state_t state_r, state_nxt;
  logic       ax_r;
  logic       pend_r;

  logic signed [31:0]  cur_r  [2];
  logic signed [31:0]  goal_r [2];
  logic signed [31:0]  vel_r  [2];
  logic signed [63:0]  c_r    [2];
  logic signed [63:0]  o_r    [2];
  logic signed [63:0]  nv_r   [2];
  logic signed [63:0]  w_r;
  logic signed [63:0]  tm_r;
  logic [30:0]         st_r;
  logic [30:0]         om_r;
  logic [60:0]         x_r, x2_r, x3_r, mc_r;
  logic [62:0]         den_r;
  logic [FRAC_BITS:0]  dec_r;
  logic [120:0]        mcsq_r;
  logic [67:0]         sq_r;
  logic [34:0]         mag_r;
  logic [127:0]        t_r;
  logic signed [99:0]  dot_r;

  logic signed [31:0]  out_x_r, out_y_r;
  logic                snapped_r;
  logic                out_valid_r;

  logic                in_acc_c;
  logic                done_c;
  logic                fire_c;
  logic                alu_st_c;
  logic                smul_c;
  logic signed [63:0]  sa_c, sb_c;
  logic                neg_c;
  logic [60:0]         uq_c;
  logic signed [63:0]  sres_c;
  logic signed [99:0]  dterm_c;
  logic                snap_c;

  assign in_acc_c = in_ch.valid && in_ch.ready;
  assign done_c   = alu_rsp.done;
  assign fire_c   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_x   = out_x_r;
  assign out_ch.out_y   = out_y_r;
  assign out_ch.snapped = snapped_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc_c) state_nxt = S_OMEGA;
      S_OMEGA: if (done_c) state_nxt = S_X;
      S_X:     if (done_c) state_nxt = S_X2;
      S_X2:    if (done_c) state_nxt = S_X3;
      S_X3:    if (done_c) state_nxt = S_T48;
      S_T48:   if (done_c) state_nxt = S_T235;
      S_T235:  if (done_c) state_nxt = S_DEC;
      S_DEC:   if (done_c) state_nxt = S_MC;
      S_MC:    if (done_c) state_nxt = S_MCSQ;
      S_MCSQ:  if (done_c) state_nxt = S_SQ;
      S_SQ:    if (done_c && ax_r) state_nxt = S_CMP;
      S_CMP:   state_nxt = ({53'd0, sq_r} > mcsq_r) ? S_MAG : S_TM1;
      S_MAG:   if (done_c) state_nxt = S_LIM_M;
      S_LIM_M: if (done_c) state_nxt = S_LIM_D;
      S_LIM_D: if (done_c) state_nxt = ax_r ? S_TM1 : S_LIM_M;
      S_TM1:   if (done_c) state_nxt = S_TM2;
      S_TM2:   if (done_c) state_nxt = S_NV1;
      S_NV1:   if (done_c) state_nxt = S_NV2;
      S_NV2:   if (done_c) state_nxt = S_OX;
      S_OX:    if (done_c) state_nxt = ax_r ? S_DOT : S_TM1;
      S_DOT:   if (done_c && ax_r) state_nxt = S_FIN;
      S_FIN:   if (fire_c) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // shared unit operands per step
  always_comb begin
    alu_req.op = OP_MUL;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_st_c   = 1'b1;
    smul_c     = 1'b0;
    sa_c       = '0;
    sb_c       = '0;
    case (state_r)
      S_OMEGA: begin
        alu_req.op = OP_DIV;
        alu_req.a  = OMEGA_NUM;
        alu_req.b  = 64'(st_r);
      end
      S_X:    begin alu_req.a = 128'(om_r);     alu_req.b = 64'(cfg.delta_time); end
      S_X2:   begin alu_req.a = 128'(x_r);      alu_req.b = 64'(x_r);  end
      S_X3:   begin alu_req.a = 128'(x2_r);     alu_req.b = 64'(x_r);  end
      S_T48:  begin alu_req.a = 128'(C48_RAW);  alu_req.b = 64'(x2_r); end
      S_T235: begin alu_req.a = 128'(C235_RAW); alu_req.b = 64'(x3_r); end
      S_DEC: begin
        alu_req.op = OP_DIV;
        alu_req.a  = DEC_NUM;
        alu_req.b  = 64'(den_r);
      end
      S_MC:   begin alu_req.a = 128'(cfg.max_speed); alu_req.b = 64'(st_r); end
      S_MCSQ: begin alu_req.a = 128'(mc_r); alu_req.b = 64'(mc_r); end
      S_SQ: begin
        alu_req.a = 128'(mag64(c_r[ax_r]));
        alu_req.b = mag64(c_r[ax_r]);
      end
      S_MAG: begin
        alu_req.op = OP_SQRT;
        alu_req.a  = 128'(sq_r);
      end
      S_LIM_M: begin
        alu_req.a = 128'(mag64(c_r[ax_r]));
        alu_req.b = 64'(mc_r);
      end
      S_LIM_D: begin
        alu_req.op = OP_DIV;
        alu_req.a  = t_r;
        alu_req.b  = 64'(mag_r);
      end
      S_TM1: begin smul_c = 1'b1; sa_c = 64'(om_r); sb_c = c_r[ax_r]; end
      S_TM2: begin smul_c = 1'b1; sa_c = w_r; sb_c = 64'(cfg.delta_time); end
      S_NV1: begin smul_c = 1'b1; sa_c = 64'(om_r); sb_c = tm_r; end
      S_NV2: begin smul_c = 1'b1; sa_c = w_r; sb_c = 64'(dec_r); end
      S_OX:  begin smul_c = 1'b1; sa_c = c_r[ax_r] + tm_r; sb_c = 64'(dec_r); end
      S_DOT: begin
        smul_c = 1'b1;
        sa_c   = 64'(goal_r[ax_r]) - 64'(cur_r[ax_r]);
        sb_c   = o_r[ax_r] - 64'(goal_r[ax_r]);
      end
      default: alu_st_c = 1'b0;
    endcase
    if (smul_c) begin
      alu_req.a = 128'(mag64(sa_c));
      alu_req.b = mag64(sb_c);
    end
    alu_req.start = alu_st_c && !pend_r;
  end

  // signed product forms
  always_comb begin
    neg_c   = sa_c[63] ^ sb_c[63];
    uq_c    = umulq_cap(alu_rsp.res);
    sres_c  = neg_c ? -$signed({3'b0, uq_c}) : $signed({3'b0, uq_c});
    dterm_c = neg_c ? -$signed({1'b0, alu_rsp.res[98:0]})
                    :  $signed({1'b0, alu_rsp.res[98:0]});
    snap_c  = !dot_r[99] && (dot_r != '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vel_r[0]    <= '0;
      vel_r[1]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (done_c) pend_r <= 1'b0;
      else if (alu_req.start) pend_r <= 1'b1;
      if (done_c && (state_r == S_SQ || state_r == S_LIM_D ||
                     state_r == S_OX || state_r == S_DOT)) begin
        ax_r <= ~ax_r;
      end
      if (fire_c) begin
        out_valid_r <= 1'b1;
        vel_r[0]    <= snap_c ? 32'sd0 : sat32(nv_r[0]);
        vel_r[1]    <= snap_c ? 32'sd0 : sat32(nv_r[1]);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: capture inputs and step results
  always_ff @(posedge clk) begin
    if (in_acc_c) begin
      cur_r[0]  <= in_ch.cur_x;
      cur_r[1]  <= in_ch.cur_y;
      goal_r[0] <= in_ch.goal_x;
      goal_r[1] <= in_ch.goal_y;
      c_r[0]    <= 64'(in_ch.cur_x) - 64'(in_ch.goal_x);
      c_r[1]    <= 64'(in_ch.cur_y) - 64'(in_ch.goal_y);
      st_r      <= (cfg.smooth_time < ST_MIN) ? ST_MIN : cfg.smooth_time;
    end
    if (done_c) begin
      case (state_r)
        S_OMEGA: om_r <= (alu_rsp.res > 128'(OMEGA_MAX)) ? OMEGA_MAX
                                                         : alu_rsp.res[30:0];
        S_X:    x_r  <= uq_c;
        S_X2:   x2_r <= uq_c;
        S_X3:   x3_r <= uq_c;
        S_T48:  den_r <= 63'(ONE_RAW) + 63'(x_r) + 63'(uq_c);
        S_T235: den_r <= den_r + 63'(uq_c);
        S_DEC:  dec_r <= alu_rsp.res[FRAC_BITS:0];
        S_MC:   mc_r <= uq_c;
        S_MCSQ: mcsq_r <= alu_rsp.res[120:0];
        S_SQ:   sq_r <= (ax_r ? sq_r : 68'd0) + alu_rsp.res[67:0];
        S_MAG:  mag_r <= (alu_rsp.res[34:0] == '0) ? 35'd1 : alu_rsp.res[34:0];
        S_LIM_M: t_r <= alu_rsp.res;
        S_LIM_D: c_r[ax_r] <= c_r[ax_r][63] ? -$signed(alu_rsp.res[63:0])
                                            :  $signed(alu_rsp.res[63:0]);
        S_TM1:  w_r <= 64'(vel_r[ax_r]) + sres_c;
        S_TM2:  tm_r <= sres_c;
        S_NV1:  w_r <= 64'(vel_r[ax_r]) - sres_c;
        S_NV2:  nv_r[ax_r] <= sres_c;
        S_OX:   o_r[ax_r] <= 64'(cur_r[ax_r]) - c_r[ax_r] + sres_c;
        S_DOT:  dot_r <= (ax_r ? dot_r : 100'sd0) + dterm_c;
        default: ;
      endcase
    end
    // load the output register
    if (fire_c) begin
      out_x_r   <= snap_c ? goal_r[0] : sat32(o_r[0]);
      out_y_r   <= snap_c ? goal_r[1] : sat32(o_r[1]);
      snapped_r <= snap_c;
    end
  end

endmodule

`default_nettype wire

@@ rtl/smooth_damp_follower_2d_top.sv @@
// ----------------------------------------------------------------------------
// smooth_damp_follower_2d_top: critically damped 2D follower
// Holds the configuration registers and joins the step sequencer to the
// shared multiply / divide / square-root unit.
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  in_ch   | sink      | cur_x, cur_y, goal_x, goal_y     | valid / ready
//  out_ch  | source    | out_x, out_y, snapped            | valid / ready
//  cfg_*   | write     | cfg_idx, cfg_data                | cfg_we
//
//  Each transaction runs two 128-step divides (omega, decay) in the shared
//  unit; under the speed limit one square root and two more divides follow.
//  One transaction at a time; in_ch.ready is high only while idle.
//  A finished result waits in the output register while the next
//  transaction is taken. Synchronous active-low reset clears velocity and
//  restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_damp_follower_2d_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]   cfg_data,
  sdf_in_if.sink                           in_ch,
  sdf_out_if.source                        out_ch
);
  import sdf_pkg::*;

  cfg_t     cfg_r;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_time <= CFG_DATA_W'(65536);
      cfg_r.max_speed   <= CFG_DATA_W'(2147483647);
      cfg_r.delta_time  <= CFG_DATA_W'(1092);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_SMOOTH_TIME: cfg_r.smooth_time <= cfg_data;
        REG_MAX_SPEED:   cfg_r.max_speed   <= cfg_data;
        REG_DELTA_TIME:  cfg_r.delta_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  sdf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  sdf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/sdf_chk.sv @@
// ----------------------------------------------------------------------------
// sdf_chk: port-level checks of the smooth damp follower
// Watches the channel handshakes of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic        snapped
);

  // busy after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transaction");

  // no result right after a transaction is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable({out_x, out_y, snapped}))
    else $error("result payload changed while stalled");

  // idle and empty after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("not idle after reset");

endmodule

bind smooth_damp_follower_2d_top sdf_chk u_sdf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .snapped   (out_ch.snapped)
);

`default_nettype wire
